/* hdl/stable_priority_queue_defines.svh */
// assertion macros shared by the stable priority queue checker
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SPQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spq check failed");

// next-cycle implication, disabled during reset
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spq check failed");

`endif

/* hdl/spq_pkg.sv */
// types and constants of the stable priority queue
`default_nettype none
package spq_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned COUNT_W = 7;

   localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_DELETE = 1'b1;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
   } entry_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic      ins;
      logic      del;
      entry_type new_entry;
   } cmd_type;

endpackage
`default_nettype wire

/* hdl/spq_cell.sv */
// one cell of the sorted entry chain
`default_nettype none
module spq_cell
   import spq_pkg::*;
(
   input  wire logic      clock,
   input  wire cmd_type   cmd,
   input  wire logic      occupied,
   input  wire logic      prev_keep,
   input  wire entry_type prev_entry,
   input  wire entry_type next_entry,
   output logic           keep,
   output entry_type      entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // an entry stays put when the new one does not outrank it (ties stay older)
   assign keep = occupied && !($signed(cmd.new_entry.prio) > $signed(entry_ff.prio));

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (!keep) begin
            entry_in = prev_keep ? cmd.new_entry : prev_entry;
         end
      end else if (cmd.del) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

/* hdl/stable_priority_queue.sv */
// top level of the stable priority queue
//
// bounded priority queue of signed 32-bit values with signed 32-bit priorities.
// req channel: one transaction is an insert (req_mode 0) or a delete (req_mode 1)
// of the highest-priority entry; among equal priorities the oldest leaves first.
// rsp channel: one transaction per request, showing the state after it: head
// value and priority, empty flag, entry count and the overflow/underflow flags.
// latency: the response is valid the cycle after the request is taken.
// throughput: one transaction per cycle while rsp_stall is low; the chain of cells
// updates every entry in parallel, each cell comparing once against the incoming priority.
// an insert into a full queue is dropped and flagged; a delete on an empty
// queue is ignored and flagged.
// reset empties the queue and drops any pending response.
// while the receiver stalls, the response holds and req_stall is raised, so no
// new request is taken until the response leaves.
`default_nettype none
module stable_priority_queue
   import spq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_mode,
   input  wire logic signed [DATA_W-1:0] req_entry_value,
   input  wire logic signed [DATA_W-1:0] req_entry_priority,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [DATA_W-1:0]      rsp_head_value,
   output logic signed [DATA_W-1:0]      rsp_head_priority,
   output logic                          rsp_is_empty,
   output logic [COUNT_W-1:0]            rsp_entry_count,
   output logic                          rsp_overflow_flag,
   output logic                          rsp_underflow_flag
);

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   // occupancy and response control
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             overflow_ff, overflow_in;
   logic             underflow_ff, underflow_in;

   logic    accept;
   logic    q_full, q_empty;
   cmd_type cmd;

   // chain wiring: entries are kept sorted, highest priority first, fifo on ties
   entry_type cell_entry [QUEUE_DEPTH];
   logic      cell_keep  [QUEUE_DEPTH];

   // a pending response blocks new requests only while it is stalled
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign q_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);

   // broadcast command; erroneous requests leave the chain untouched
   always_comb begin
      cmd.ins             = accept && (req_mode == MODE_INSERT) && !q_full;
      cmd.del             = accept && (req_mode == MODE_DELETE) && !q_empty;
      cmd.new_entry.value = req_entry_value;
      cmd.new_entry.prio  = req_entry_priority;
   end

   always_comb begin
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      underflow_in = underflow_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (cmd.ins) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.del) begin
         count_in = count_ff - 1'b1;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         overflow_in  = (req_mode == MODE_INSERT) && q_full;
         underflow_in = (req_mode == MODE_DELETE) && q_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      overflow_ff  <= overflow_in;
      underflow_ff <= underflow_in;
   end

   // row of cells; cell zero always holds the head
   for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      logic      occupied;
      logic      prev_keep;
      entry_type prev_entry;
      entry_type next_entry;

      assign occupied = (count_ff > CNT_W'(gi));

      if (gi == 0) begin : g_first
         // nothing ahead of the head: a new entry lands here unless cell zero stays
         assign prev_keep  = 1'b1;
         assign prev_entry = cmd.new_entry;
      end else begin : g_inner
         assign prev_keep  = cell_keep[gi-1];
         assign prev_entry = cell_entry[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_last
         // tail cell shifts in its own content; it is unoccupied after a delete
         assign next_entry = cell_entry[gi];
      end else begin : g_body
         assign next_entry = cell_entry[gi+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (occupied),
         .prev_keep  (prev_keep),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .keep       (cell_keep[gi]),
         .entry      (cell_entry[gi])
      );
   end

   // response fields come straight from state, which holds while stalled
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_empty       = q_empty;
   assign rsp_head_value     = q_empty ? '0 : cell_entry[0].value;
   assign rsp_head_priority  = q_empty ? INT_MIN : cell_entry[0].prio;
   assign rsp_entry_count    = COUNT_W'(count_ff);
   assign rsp_overflow_flag  = overflow_ff;
   assign rsp_underflow_flag = underflow_ff;

endmodule
`default_nettype wire

/* hdl/spq_checker.sv */
// port-level checks of the stable priority queue and their bind
`default_nettype none
`include "stable_priority_queue_defines.svh"
module spq_checker
   import spq_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic                     req_mode,
   input wire logic signed [DATA_W-1:0] req_entry_value,
   input wire logic signed [DATA_W-1:0] req_entry_priority,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic signed [DATA_W-1:0] rsp_head_value,
   input wire logic signed [DATA_W-1:0] rsp_head_priority,
   input wire logic                     rsp_is_empty,
   input wire logic [COUNT_W-1:0]       rsp_entry_count,
   input wire logic                     rsp_overflow_flag,
   input wire logic                     rsp_underflow_flag
);

   logic req_accept;
   logic req_insert_seen;

   assign req_accept      = req_valid & ~req_stall;
   assign req_insert_seen = req_accept & (req_mode == MODE_INSERT)
                            & (req_entry_value == req_entry_value)
                            & (req_entry_priority == req_entry_priority);

   // every taken request yields a response on the next cycle
   `SPQ_ASSERT_NEXT(a_rsp_follows_req, clock, reset, req_accept, rsp_valid)

   // an empty queue shows the reset head and a zero count
   `SPQ_ASSERT_NOW(a_empty_head, clock, reset, rsp_valid && rsp_is_empty,
      rsp_head_value == '0 && rsp_head_priority == INT_MIN && rsp_entry_count == '0)

   // the two error flags never come together, and an underflow leaves it empty
   `SPQ_ASSERT_NOW(a_flags, clock, reset, rsp_valid && rsp_underflow_flag,
      !rsp_overflow_flag && rsp_is_empty)

   // an insert never leaves the queue empty
   `SPQ_ASSERT_NEXT(a_insert_not_empty, clock, reset, req_insert_seen, !rsp_is_empty)

   // a stalled response holds its head
   `SPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_head_value) && $stable(rsp_head_priority))

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);
`default_nettype wire
